>>> rtl/core/gamma_correction_rgb_unit_assert.svh
// Assertion macros for the gamma correction unit.
// Needs a clock named clk and a reset named rst in the including module.
`ifndef GAMMA_CORRECTION_RGB_UNIT_ASSERT_SVH
`define GAMMA_CORRECTION_RGB_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define GCR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the following cycle
`define GCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/gcr_pkg.sv
// Shared types, constants and elaboration-time table generators for the
// gamma correction unit. No dependencies.
package gcr_pkg;

  localparam int N_STAGES = 20;   // pipeline depth, input to output register
  localparam int EW       = 21;   // exponent, Q5.16 (up to 8.0)
  localparam int LW       = 20;   // log2 ratio magnitude, Q.16
  localparam int MW       = 25;   // scaled magnitude, Q.16
  localparam int AW       = 32;   // exp2 accumulator, Q.30

  localparam logic REG_GAMMA = 1'b0;   // word index of gamma_setting

  typedef logic [AW-1:0] root_tab_t [16];
  typedef logic [EW-1:0] exp_tab_t  [256];
  typedef logic [LW-1:0] lmag_tab_t [256];

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bv;
    logic [63:0] x;
    res = '0;
    x   = v;
    bv  = 64'h1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + bv) begin
        x   = x - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // successive roots 2^(2^-(k+1)) in Q.30
  function automatic root_tab_t root_table();
    root_tab_t   t;
    logic [63:0] r;
    r = 64'h2 << 30;
    for (int k = 0; k < 16; k++) begin
      r    = isqrt64(r << 30);
      t[k] = r[AW-1:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOT = root_table();

  function automatic logic [63:0] exp2_frac(input logic [15:0] f);
    logic [63:0] acc;
    acc = 64'h1 << 30;
    for (int k = 0; k < 16; k++) begin
      if (f[15-k]) acc = (acc * {32'h0, ROOT[k]}) >> 30;
    end
    return acc;
  endfunction

  function automatic logic [31:0] log2_q16(input logic [31:0] x);
    int          p;
    logic [63:0] m;
    logic [31:0] res;
    p = 0;
    for (int j = 0; j < 31; j++) begin
      if ((x >> (j + 1)) != 0) p = j + 1;
    end
    m   = {32'h0, x} << (30 - p);
    res = 32'(p) << 16;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'h1 << 31)) begin
        m   = m >> 1;
        res = res | (32'h1 << i);
      end
    end
    return res;
  endfunction

  // exponent in Q5.16, indexed by the raw setting bits
  function automatic exp_tab_t exp_table();
    exp_tab_t    t;
    longint      s;
    longint      u;
    logic [63:0] p;
    logic [7:0]  b;
    for (int i = 0; i < 256; i++) begin
      b    = 8'(i);
      s    = longint'(signed'(b));
      u    = 196608 - 1536 * s;
      p    = exp2_frac(16'(u & 65535));
      p    = (p << (u >> 16)) >> 17;
      t[i] = p[EW-1:0];
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = exp_table();

  // log2(cmax) - log2(min(c, cmax)) in Q.16, per channel code
  function automatic lmag_tab_t lmag_table(input int cmax);
    lmag_tab_t   t;
    int          cc;
    logic [31:0] lm;
    for (int c = 0; c < 256; c++) begin
      cc = (c > cmax) ? cmax : c;
      if (c == 0) begin
        t[c] = '0;
      end else begin
        lm   = log2_q16(32'(cmax)) - log2_q16(32'(cc));
        t[c] = lm[LW-1:0];
      end
    end
    return t;
  endfunction

endpackage

>>> rtl/core/gcr_chan.sv
// One colour channel of the gamma pipeline: log lookup, exponent scaling,
// bit-serial exp2 over sixteen stages, final scale and clamp. Uses gcr_pkg.
module gcr_chan import gcr_pkg::*; #(
  parameter int CHANNEL_MAX = 255
) (
  input  logic                clk,
  input  logic [N_STAGES-1:0] en,
  input  logic [7:0]          c,
  input  logic [EW-1:0]       e,
  output logic [7:0]          r
);

  localparam int        CW   = $clog2(CHANNEL_MAX + 1);
  localparam int        PW   = CW + AW;
  localparam int        LIMV = (CHANNEL_MAX > 255) ? 255 : CHANNEL_MAX;
  localparam logic [CW-1:0] CMAX = CW'(CHANNEL_MAX);
  localparam logic [PW-1:0] LIM  = PW'(LIMV);
  localparam lmag_tab_t LMAG = lmag_table(CHANNEL_MAX);

  typedef struct packed {
    logic          zero;
    logic          fz;
    logic [4:0]    n;
    logic [15:0]   g;
    logic [AW-1:0] acc;
  } xs_t;

  // stage 0
  logic          z0;
  logic [LW-1:0] lm;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      z0 <= (c == 8'd0);
      lm <= LMAG[c];
    end
  end

  // stage 1: scale by exponent
  logic [LW+EW-1:0] prod1;
  logic [MW-1:0]    mag;
  xs_t              xs [17];
  assign prod1 = {{EW{1'b0}}, lm} * {{LW{1'b0}}, e};
  assign mag   = prod1[MW+15:16];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      xs[0].zero <= z0 | (mag[MW-1:16] >= 9'd17);
      xs[0].fz   <= (mag[15:0] == 16'd0);
      xs[0].n    <= mag[20:16];
      xs[0].g    <= 16'(~mag[15:0] + 16'd1);
      xs[0].acc  <= AW'(64'h1 << 30);
    end
  end

  // stages 2..17: one root factor each
  for (genvar k = 0; k < 16; k++) begin : g_exp
    logic [2*AW-1:0] pm;
    assign pm = xs[k].acc * ROOT[k];
    always_ff @(posedge clk) begin
      if (en[k+2]) begin
        xs[k+1].zero <= xs[k].zero;
        xs[k+1].fz   <= xs[k].fz;
        xs[k+1].n    <= xs[k].n;
        xs[k+1].g    <= xs[k].g;
        xs[k+1].acc  <= xs[k].g[15-k] ? pm[AW+29:30] : xs[k].acc;
      end
    end
  end

  // stage 18: multiply by full scale
  logic          z18;
  logic          fz18;
  logic [4:0]    n18;
  logic [PW-1:0] p18;
  always_ff @(posedge clk) begin
    if (en[18]) begin
      z18  <= xs[16].zero;
      fz18 <= xs[16].fz;
      n18  <= xs[16].n;
      p18  <= {{AW{1'b0}}, CMAX} * {{CW{1'b0}}, xs[16].acc};
    end
  end

  // stage 19: shift and clamp
  logic [PW-1:0] sh;
  logic [PW-1:0] cl;
  always_comb begin
    if (fz18) sh = {{AW{1'b0}}, CMAX} >> n18;
    else      sh = p18 >> (6'd31 + {1'b0, n18});
    cl = (sh > LIM) ? LIM : sh;
  end

  always_ff @(posedge clk) begin
    if (en[19]) r <= z18 ? 8'd0 : cl[7:0];
  end

endmodule

>>> rtl/core/gamma_correction_rgb_unit.sv
// Gamma correction unit: each colour channel c becomes
// CHANNEL_MAX*(c/CHANNEL_MAX)^e, e = 2^(-gamma_setting*3/128); alpha passes.
// Uses gcr_pkg and gcr_chan.
//
// One pixel per clock cycle sustained while res_stall stays low; twenty register
// stages, set by the sixteen exp2 stages plus log, scale, product and output
// stages. Stalls collapse bubbles stage by stage. gamma_setting sits at byte
// address 0 and is to be written only while no pixel is in flight; it applies
// to pixels accepted after the write.
module gamma_correction_rgb_unit import gcr_pkg::*; #(
  parameter int CHANNEL_MAX = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        pix_valid,
  output logic        pix_stall,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic [7:0]  alpha_in,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic [7:0]  alpha_out
);

`include "gamma_correction_rgb_unit_assert.svh"

  localparam int LIMV = (CHANNEL_MAX > 255) ? 255 : CHANNEL_MAX;

  logic [7:0]          gamma;
  logic [EW-1:0]       e_q;
  logic [N_STAGES-1:0] v;
  logic [N_STAGES-1:0] rdy;
  logic [7:0]          alpha_p [N_STAGES];

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_GAMMA) ? {24'h0, gamma} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= 8'h00;
    end else if (psel && penable && pwrite && paddr[2] == REG_GAMMA) begin
      gamma <= pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    e_q <= EXP_TAB[gamma];
  end

  always_comb begin
    rdy[N_STAGES-1] = !v[N_STAGES-1] || !res_stall;
    for (int i = N_STAGES - 2; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign pix_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= pix_valid;
      for (int i = 1; i < N_STAGES; i++) begin
        if (rdy[i]) v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) alpha_p[0] <= alpha_in;
    for (int i = 1; i < N_STAGES; i++) begin
      if (rdy[i]) alpha_p[i] <= alpha_p[i-1];
    end
  end

  gcr_chan #(.CHANNEL_MAX(CHANNEL_MAX)) u_red (
    .clk(clk), .en(rdy), .c(red_in), .e(e_q), .r(red_out)
  );
  gcr_chan #(.CHANNEL_MAX(CHANNEL_MAX)) u_green (
    .clk(clk), .en(rdy), .c(green_in), .e(e_q), .r(green_out)
  );
  gcr_chan #(.CHANNEL_MAX(CHANNEL_MAX)) u_blue (
    .clk(clk), .en(rdy), .c(blue_in), .e(e_q), .r(blue_out)
  );

  assign res_valid = v[N_STAGES-1];
  assign alpha_out = alpha_p[N_STAGES-1];

  `GCR_ASSERT_IMPL(a_no_stall_when_empty, !res_valid, !pix_stall, "input stalled with empty output")
  `GCR_ASSERT_IMPL(a_red_range, res_valid, red_out <= 8'(LIMV), "red beyond channel limit")
  `GCR_ASSERT_NEXT(a_exp_tracks, 1'b1, e_q == EXP_TAB[$past(gamma)], "exponent register stale")

endmodule

>>> sim/gamma_correction_rgb_checker.sv
// Checker for the gamma correction unit: watches the pixel and result channels
// and the config port, predicts each corrected pixel, compares in order.
// Depends on gcr_pkg for the register index only.
module gamma_correction_rgb_checker import gcr_pkg::*; #(
  parameter int CHANNEL_MAX = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pix_valid,
  input  logic        pix_stall,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic [7:0]  alpha_in,
  input  logic        res_valid,
  input  logic        res_stall,
  input  logic [7:0]  red_out,
  input  logic [7:0]  green_out,
  input  logic [7:0]  blue_out,
  input  logic [7:0]  alpha_out,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] r, g, b, a;
  } pixel_t;

  pixel_t          corrected_q[$];
  logic signed [7:0] slider;
  logic [63:0]     half_roots [16];

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] acc, bitv, x;
    acc = 0; x = v; bitv = 64'h1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= acc + bitv) begin
        x = x - (acc + bitv);
        acc = (acc >> 1) + bitv;
      end else begin
        acc = acc >> 1;
      end
      bitv = bitv >> 2;
    end
    return acc;
  endfunction

  function automatic logic [63:0] pow2_fraction(input logic [15:0] f);
    logic [63:0] acc;
    acc = 64'h1 << 30;
    for (int i = 15; i >= 0; i--)
      if (f[i]) acc = (acc * half_roots[15-i]) >> 30;
    return acc;
  endfunction

  function automatic logic [31:0] log2_fixed(input logic [31:0] x);
    int          msb;
    logic [63:0] m;
    logic [31:0] res;
    msb = 0;
    while (msb < 31 && (x >> (msb + 1)) != 0) msb++;
    m = 64'(x) << (30 - msb);
    res = 32'(msb) << 16;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'h1 << 31)) begin
        m = m >> 1;
        res[i] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [63:0] gamma_exponent(input logic signed [7:0] s);
    longint      u;
    logic [63:0] p;
    u = 196608 - 1536 * longint'(s);
    p = pow2_fraction(16'(u & 65535));
    return (p << (u >> 16)) >> 17;
  endfunction

  function automatic logic [7:0] correct_level(input logic [7:0] c_in, input logic [63:0] e);
    longint      lmag;
    logic [63:0] mag, r, lim, c;
    lim = (CHANNEL_MAX > 255) ? 255 : CHANNEL_MAX;
    c = c_in;
    if (c == 0) return 0;
    if (c > CHANNEL_MAX) c = CHANNEL_MAX;
    lmag = longint'(log2_fixed(CHANNEL_MAX)) - longint'(log2_fixed(32'(c)));
    if (lmag < 0) lmag = 0;
    mag = (64'(lmag) * e) >> 16;
    if (mag >= (64'd17 << 16)) return 0;
    if (mag[15:0] == 0)
      r = (64'(CHANNEL_MAX) << 30) >> (30 + mag[63:16]);
    else
      r = (64'(CHANNEL_MAX) * pow2_fraction(16'(65536 - mag[15:0]))) >> (31 + mag[63:16]);
    if (r > lim) r = lim;
    return r[7:0];
  endfunction

  initial begin
    logic [63:0] rt;
    rt = 64'h2 << 30;
    for (int k = 0; k < 16; k++) begin
      rt = int_sqrt(rt << 30);
      half_roots[k] = rt;
    end
  end

  always @(posedge clk) begin
    pixel_t      exp_px;
    logic [63:0] e;
    if (rst) begin
      slider <= 0;
      fail_count <= 0;
      pending <= 0;
      corrected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_GAMMA)
        slider <= pwdata[7:0];
      if (pix_valid && !pix_stall) begin
        e = gamma_exponent(slider);
        corrected_q.push_back({correct_level(red_in, e), correct_level(green_in, e),
                               correct_level(blue_in, e), alpha_in});
      end
      if (res_valid && !res_stall) begin
        if (corrected_q.size() == 0) begin
          $display("%0t: unexpected result r=%0d g=%0d b=%0d a=%0d", $time,
                   red_out, green_out, blue_out, alpha_out);
          fail_count <= fail_count + 1;
        end else begin
          exp_px = corrected_q.pop_front();
          if (exp_px != {red_out, green_out, blue_out, alpha_out}) begin
            $display("%0t: mismatch expected r=%0d g=%0d b=%0d a=%0d actual r=%0d g=%0d b=%0d a=%0d",
                     $time, exp_px.r, exp_px.g, exp_px.b, exp_px.a,
                     red_out, green_out, blue_out, alpha_out);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= corrected_q.size();
    end
  end
endmodule

>>> sim/tb_top.sv
// Top of the gamma correction testbench: clock, reset, config writes and
// pixel stimulus with random idling; verdict from gamma_correction_rgb_checker.
// Depends on gcr_pkg, gamma_correction_rgb_unit and gamma_correction_rgb_checker.
module tb_top import gcr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk, rst;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pix_valid, pix_stall, res_valid, res_stall;
  logic [7:0]  red_in, green_in, blue_in, alpha_in;
  logic [7:0]  red_out, green_out, blue_out, alpha_out;
  int          fail_count, pending;
  bit          calm;

  gamma_correction_rgb_unit dut (.*);
  gamma_correction_rgb_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) res_stall <= 0;
    else res_stall <= !calm && ($urandom_range(99) < 24);
  end

  task automatic write_gamma(input logic [7:0] s);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= 3'(REG_GAMMA) << 2; pwdata <= {24'h0, s};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic [7:0] r, g, b, a);
    while (!calm && $urandom_range(99) < 24) begin
      pix_valid <= 0;
      @(posedge clk);
    end
    pix_valid <= 1;
    red_in <= r; green_in <= g; blue_in <= b; alpha_in <= a;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
  endtask

  // wait for a clock edge first so the count includes the last accepted pixel
  task automatic drain_pipe();
    pix_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    logic [7:0] settings [8] = '{8'h00, 8'h80, 8'h7f, 8'hff, 8'h01, 8'hc0, 8'h40, 8'h00};
    logic [7:0] edge_vals [6] = '{8'd0, 8'd1, 8'd2, 8'd128, 8'd254, 8'd255};
    rst = 1; calm = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    pix_valid = 0; red_in = 0; green_in = 0; blue_in = 0; alpha_in = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: field extremes under default gamma, then the two extreme settings and 0xff
    foreach (edge_vals[i])
      send_pixel(edge_vals[i], edge_vals[5-i], edge_vals[i] ^ 8'h55, edge_vals[5-i]);
    drain_pipe();
    for (int k = 1; k < 4; k++) begin
      write_gamma(settings[k]);
      foreach (edge_vals[i])
        send_pixel(edge_vals[i], edge_vals[(i+2)%6], edge_vals[5-i], edge_vals[i]);
      drain_pipe();
    end
    // random phases, several settings, one stretch without idling
    for (int ph = 0; ph < 9; ph++) begin
      write_gamma(ph < 4 ? settings[ph+4] : 8'($urandom));
      calm = (ph == 2);
      repeat (50)
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      drain_pipe();
    end
    calm = 0;
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
